@@ rtl/core/lszc_pkg.sv @@
// Shared types, widths and codes for the lidar sector zone classifier.
`default_nettype none
package lszc_pkg;

   // Field widths
   localparam int ANGLE_W  = 9;
   localparam int RANGE_W  = 16;
   localparam int DIST_W   = 16;
   localparam int SUM_W    = 22;
   localparam int ZONE_W   = 3;
   localparam int STATE_W  = 3;
   localparam int CSR_IDX_W = 3;

   // Geometry
   localparam int SECTOR_COUNT        = 3;
   localparam int SECTOR_SAMPLES_DEF  = 40;
   localparam int FULL_TURN           = 360;
   localparam int RSP_FIFO_DEPTH      = 4;

   // Saturation ceiling of a sector accumulator
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_DIST    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ANGLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_MARGIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDEAL_MARGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_MARGIN = 3'd4;

   // Register reset values
   localparam logic [DIST_W-1:0]  WALL_DIST_RST    = 16'd500;
   localparam logic [ANGLE_W-1:0] START_ANGLE_RST  = 9'd350;
   localparam logic [DIST_W-1:0]  WIDE_MARGIN_RST  = 16'd100;
   localparam logic [DIST_W-1:0]  IDEAL_MARGIN_RST = 16'd30;
   localparam logic [DIST_W-1:0]  OUTER_MARGIN_RST = 16'd80;

   // Distance band of the forward and left sectors
   typedef enum logic [ZONE_W-1:0] {
      ZONE_COLLISION   = 3'd0,
      ZONE_CLOSE       = 3'd1,
      ZONE_IDEAL       = 3'd2,
      ZONE_SLIGHT_FAR  = 3'd3,
      ZONE_FAR         = 3'd4
   } zone_type;

   // Front-left sector band
   typedef enum logic [ZONE_W-1:0] {
      SIDE_NOT_FAR = 3'd1,
      SIDE_FAR     = 3'd3
   } side_type;

   // Robot state codes
   typedef enum logic [STATE_W-1:0] {
      ST_HEAD_ON      = 3'd0,
      ST_PARALLEL_HIT = 3'd1,
      ST_CORNER_AHEAD = 3'd2,
      ST_EDGE         = 3'd3,
      ST_NEAR         = 3'd4,
      ST_IDEAL        = 3'd5,
      ST_TOO_FAR      = 3'd6
   } state_type;

   // One classified scan
   typedef struct packed {
      state_type robot_state;
      zone_type  forward_zone;
      side_type  front_left_zone;
      zone_type  left_zone;
   } rsp_type;

   // Scan ends still in flight ahead of the result queue
   typedef struct packed {
      logic in_last;
      logic snap_last;
   } accum_status_type;

   typedef logic [SECTOR_COUNT-1:0][SUM_W-1:0] sums_type;

endpackage
`default_nettype wire

@@ rtl/core/lszc_accum.sv @@
// Input register, sector decode and saturating per-sector accumulation.
`default_nettype none
module lszc_accum
   import lszc_pkg::*;
#(
   parameter int SECTOR_SAMPLES = SECTOR_SAMPLES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_take,
   input  wire [ANGLE_W-1:0]     in_angle,
   input  wire [RANGE_W-1:0]     in_range,
   input  wire                   in_last,
   input  wire [ANGLE_W-1:0]     start_angle,
   output sums_type              snap_sums,
   output logic                  snap_valid,
   output accum_status_type      status
);

   localparam int BOUND_W = ANGLE_W + 1;
   localparam logic [BOUND_W-1:0] BOUND0 = BOUND_W'(SECTOR_SAMPLES);
   localparam logic [BOUND_W-1:0] BOUND1 = BOUND_W'(2 * SECTOR_SAMPLES);
   localparam logic [BOUND_W-1:0] BOUND2 = BOUND_W'(3 * SECTOR_SAMPLES);
   localparam logic [ANGLE_W-1:0] TURN   = ANGLE_W'(FULL_TURN);

   // Input register
   logic                 in_valid_ff;
   logic [ANGLE_W-1:0]   angle_ff;
   logic [RANGE_W-1:0]   range_ff;
   logic                 last_ff;

   // Running sums and the snapshot taken at scan end
   sums_type             sums_ff, sums_in;
   sums_type             snap_ff, snap_in;
   logic                 snap_valid_ff;

   logic [ANGLE_W-1:0]   base;
   logic [ANGLE_W-1:0]   offset;
   logic [BOUND_W-1:0]   offset_x;
   logic                 in_range_ok;
   logic [SECTOR_COUNT-1:0] hit;
   sums_type             added;
   logic [SUM_W:0]       wide_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_take;
      end
      if (in_take) begin
         angle_ff <= in_angle;
         range_ff <= in_range;
         last_ff  <= in_last;
      end
   end

   // Sector decode: offset from the start angle, modulo a full turn
   always_comb begin
      base        = (start_angle >= TURN) ? start_angle - TURN : start_angle;
      in_range_ok = (angle_ff < TURN);
      offset      = (angle_ff >= base) ? angle_ff - base : angle_ff + (TURN - base);
      offset_x    = BOUND_W'(offset);
      hit[0] = in_valid_ff && in_range_ok && (offset_x < BOUND0);
      hit[1] = in_valid_ff && in_range_ok && (offset_x >= BOUND0) && (offset_x < BOUND1);
      hit[2] = in_valid_ff && in_range_ok && (offset_x >= BOUND1) && (offset_x < BOUND2);
   end

   // Saturating add into the hit sector; scan end moves sums to the snapshot
   always_comb begin
      wide_sum = '0;
      for (int k = 0; k < SECTOR_COUNT; k++) begin
         wide_sum = {1'b0, sums_ff[k]} + (SUM_W + 1)'(range_ff);
         if (hit[k]) begin
            added[k] = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
         end else begin
            added[k] = sums_ff[k];
         end
      end
      if (in_valid_ff && last_ff) begin
         sums_in = '0;
         snap_in = added;
      end else begin
         sums_in = added;
         snap_in = snap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         sums_ff       <= sums_in;
         snap_valid_ff <= in_valid_ff && last_ff;
      end
      snap_ff <= snap_in;
   end

   assign snap_sums        = snap_ff;
   assign snap_valid       = snap_valid_ff;
   assign status.in_last   = in_valid_ff && last_ff;
   assign status.snap_last = snap_valid_ff;

endmodule
`default_nettype wire

@@ rtl/core/lszc_classify.sv @@
// Threshold registers, distance band compares and robot state mapping.
`default_nettype none
module lszc_classify
   import lszc_pkg::*;
#(
   parameter int SECTOR_SAMPLES = SECTOR_SAMPLES_DEF
) (
   input  wire               clock,
   input  wire [DIST_W-1:0]  wall_dist,
   input  wire [DIST_W-1:0]  wide_margin,
   input  wire [DIST_W-1:0]  ideal_margin,
   input  wire [DIST_W-1:0]  outer_margin,
   input  wire sums_type     sums,
   output rsp_type           result
);

   localparam int SW     = $clog2(SECTOR_SAMPLES + 1);
   localparam int DIFF_W = DIST_W + 2;
   localparam int PROD_W = DIFF_W + SW + 1;
   localparam int CMP_W  = (PROD_W > SUM_W + 1) ? PROD_W : SUM_W + 1;
   localparam logic signed [SW:0] S_SGN = (SW + 1)'(SECTOR_SAMPLES);

   logic signed [DIFF_W-1:0] d_minus_w, d_minus_i, d_plus_i, d_plus_o, d_plus_w;
   logic signed [CMP_W-1:0]  lim_coll_ff, lim_close_ff, lim_ideal_ff, lim_slight_ff;
   logic signed [CMP_W-1:0]  lim_side_ff;
   logic signed [CMP_W-1:0]  lim_coll_in, lim_close_in, lim_ideal_in, lim_slight_in;
   logic signed [CMP_W-1:0]  lim_side_in;
   zone_type                 fwd, lft;
   side_type                 side;
   state_type                state;

   // Band edges scaled by the sector width, recomputed from the registers
   always_comb begin
      d_minus_w = $signed({2'b00, wall_dist}) - $signed({2'b00, wide_margin});
      d_minus_i = $signed({2'b00, wall_dist}) - $signed({2'b00, ideal_margin});
      d_plus_i  = $signed({2'b00, wall_dist}) + $signed({2'b00, ideal_margin});
      d_plus_o  = $signed({2'b00, wall_dist}) + $signed({2'b00, outer_margin});
      d_plus_w  = $signed({2'b00, wall_dist}) + $signed({2'b00, wide_margin});
      lim_coll_in   = CMP_W'(d_minus_w) * CMP_W'(S_SGN);
      lim_close_in  = CMP_W'(d_minus_i) * CMP_W'(S_SGN);
      lim_ideal_in  = CMP_W'(d_plus_i) * CMP_W'(S_SGN);
      lim_slight_in = CMP_W'(d_plus_o) * CMP_W'(S_SGN);
      lim_side_in   = CMP_W'(d_plus_w) * CMP_W'(S_SGN);
   end

   always_ff @(posedge clock) begin
      lim_coll_ff   <= lim_coll_in;
      lim_close_ff  <= lim_close_in;
      lim_ideal_ff  <= lim_ideal_in;
      lim_slight_ff <= lim_slight_in;
      lim_side_ff   <= lim_side_in;
   end

   function automatic logic signed [CMP_W-1:0] widen(input logic [SUM_W-1:0] s);
      return $signed({(CMP_W - SUM_W)'(0), s});
   endfunction

   // First band that holds wins
   function automatic zone_type band(input logic [SUM_W-1:0] s);
      logic signed [CMP_W-1:0] v;
      v = widen(s);
      if (v <= lim_coll_ff) begin
         return ZONE_COLLISION;
      end else if (v < lim_close_ff) begin
         return ZONE_CLOSE;
      end else if (v <= lim_ideal_ff) begin
         return ZONE_IDEAL;
      end else if (v <= lim_slight_ff) begin
         return ZONE_SLIGHT_FAR;
      end else begin
         return ZONE_FAR;
      end
   endfunction

   always_comb begin
      fwd  = band(sums[0]);
      lft  = band(sums[2]);
      side = (widen(sums[1]) > lim_side_ff) ? SIDE_FAR : SIDE_NOT_FAR;
   end

   // Zone triple to robot state
   always_comb begin
      case (fwd)
         ZONE_COLLISION: state = ST_HEAD_ON;
         ZONE_FAR: begin
            if (lft == ZONE_COLLISION) begin
               state = ST_PARALLEL_HIT;
            end else if (side == SIDE_FAR) begin
               state = (lft == ZONE_SLIGHT_FAR || lft == ZONE_FAR) ? ST_TOO_FAR : ST_IDEAL;
            end else begin
               state = (lft == ZONE_SLIGHT_FAR || lft == ZONE_FAR) ? ST_EDGE : ST_NEAR;
            end
         end
         default: state = ST_CORNER_AHEAD;
      endcase
   end

   assign result.robot_state     = state;
   assign result.forward_zone    = fwd;
   assign result.front_left_zone = side;
   assign result.left_zone       = lft;

endmodule
`default_nettype wire

@@ rtl/core/lszc_fifo.sv @@
// Small result queue that decouples the pipeline from the receiver.
`default_nettype none
module lszc_fifo
   import lszc_pkg::*;
#(
   parameter int WIDTH = 12,
   parameter int DEPTH = RSP_FIFO_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        wr_en,
   input  wire  [WIDTH-1:0]           wr_data,
   input  wire                        rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({wr_en, rd_en})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data   = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule
`default_nettype wire

@@ rtl/core/lidar_sector_zone_classifier.sv @@
// Lidar sector zone classifier: configuration registers and top level.
//
// Usage:
//  - req channel carries one range sample (angle, range, scan_end) per transfer.
//    Samples in the forward, front-left and left sectors, each SECTOR_SAMPLES
//    degrees wide from start_angle, are summed with saturation.
//  - A sample with scan_end set closes the scan: it is summed first, then one
//    rsp transfer carries the robot state and the three zone codes, and the
//    sums restart from zero. Other samples produce no result.
//  - csr port: write-only registers, taken on every cycle csr_wr_en is high;
//    write them only while no sample is still in flight.
//  - Throughput: one sample per cycle while req_stall is low. A result is
//    offered on rsp once its scan-end sample has passed the input register,
//    the accumulate/snapshot register and then the result queue.
//  - rsp_stall holds results in a four-entry queue; req_stall rises once the
//    queue plus the scan ends in the two pipeline stages would fill it.
//  - Reset (synchronous) clears sums, pipeline valids and the queue and
//    loads the register defaults.
`default_nettype none
module lidar_sector_zone_classifier
   import lszc_pkg::*;
#(
   parameter int SECTOR_SAMPLES = SECTOR_SAMPLES_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   // Sample input
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [ANGLE_W-1:0]   req_angle_deg,
   input  wire  [RANGE_W-1:0]   req_range_mm,
   input  wire                  req_scan_end,
   // Result output
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [STATE_W-1:0]   rsp_robot_state,
   output logic [ZONE_W-1:0]    rsp_forward_zone,
   output logic [ZONE_W-1:0]    rsp_front_left_zone,
   output logic [ZONE_W-1:0]    rsp_left_zone,
   // Register writes
   input  wire                  csr_wr_en,
   input  wire  [CSR_IDX_W-1:0] csr_addr,
   input  wire  [DIST_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int OCC_W = CNT_W + 1;

   // Configuration registers
   logic [DIST_W-1:0]  wall_dist_ff;
   logic [ANGLE_W-1:0] start_angle_ff;
   logic [DIST_W-1:0]  wide_margin_ff;
   logic [DIST_W-1:0]  ideal_margin_ff;
   logic [DIST_W-1:0]  outer_margin_ff;

   logic               req_take;
   logic               rsp_take;
   sums_type           snap_sums;
   logic               snap_valid;
   accum_status_type   status;
   rsp_type            result;
   rsp_type            head;
   logic [CNT_W-1:0]   q_count;
   logic [OCC_W-1:0]   occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_dist_ff    <= WALL_DIST_RST;
         start_angle_ff  <= START_ANGLE_RST;
         wide_margin_ff  <= WIDE_MARGIN_RST;
         ideal_margin_ff <= IDEAL_MARGIN_RST;
         outer_margin_ff <= OUTER_MARGIN_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_WALL_DIST:    wall_dist_ff    <= csr_wdata;
            CSR_START_ANGLE:  start_angle_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_WIDE_MARGIN:  wide_margin_ff  <= csr_wdata;
            CSR_IDEAL_MARGIN: ideal_margin_ff <= csr_wdata;
            CSR_OUTER_MARGIN: outer_margin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stall when queued plus in-flight results could overrun the queue
   always_comb begin
      occupancy = OCC_W'(q_count) + OCC_W'(status.in_last) + OCC_W'(status.snap_last);
      req_stall = (occupancy >= OCC_W'(RSP_FIFO_DEPTH));
   end

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   lszc_accum #(
      .SECTOR_SAMPLES (SECTOR_SAMPLES)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_take     (req_take),
      .in_angle    (req_angle_deg),
      .in_range    (req_range_mm),
      .in_last     (req_scan_end),
      .start_angle (start_angle_ff),
      .snap_sums   (snap_sums),
      .snap_valid  (snap_valid),
      .status      (status)
   );

   lszc_classify #(
      .SECTOR_SAMPLES (SECTOR_SAMPLES)
   ) u_classify (
      .clock        (clock),
      .wall_dist    (wall_dist_ff),
      .wide_margin  (wide_margin_ff),
      .ideal_margin (ideal_margin_ff),
      .outer_margin (outer_margin_ff),
      .sums         (snap_sums),
      .result       (result)
   );

   lszc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (snap_valid),
      .wr_data   (result),
      .rd_en     (rsp_take),
      .rd_data   (head),
      .not_empty (rsp_valid),
      .count     (q_count)
   );

   assign rsp_robot_state     = head.robot_state;
   assign rsp_forward_zone    = head.forward_zone;
   assign rsp_front_left_zone = head.front_left_zone;
   assign rsp_left_zone       = head.left_zone;

endmodule
`default_nettype wire
